[hdl/uart_cfp_pkg.sv]
// Shared constants and types for the UART command frame parser.
package uart_cfp_pkg;

   localparam int TALLY_ENTRIES_DEF = 40;
   localparam int REQ_W = 8;
   localparam int RSP_W = 32;

   localparam logic [7:0] BYTE_START    = 8'hF0;
   localparam logic [7:0] FUNC_CMD_ONLY = 8'h0C;
   localparam logic [7:0] FUNC_CMD_DATA = 8'h0B;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_LF       = 8'h0A;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_FUNC,
      PH_BODY,
      PH_CR,
      PH_LF
   } phase_type;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] payload;
      logic       counted;
   } finish_type;

endpackage

[hdl/uart_command_frame_parser.sv]
// Top level: UART command frame parser with per-command frame counters.
//
// Usage:
//   req_* carries one received UART byte per transaction (req_tdata[7:0]).
//   rsp_* carries one transaction per completed frame F0, fn, cmd, [data], 0D, 0A.
//   csr_* writes frame_mode (csr_data[0]); write it only while the block is idle.
// Path: a closing 0x0A passes the input register, the counter read stage and
//   the output register before it shows on rsp_tvalid.
// Throughput: one byte per cycle while req_tready is high; the counter table is
//   read in one stage, written back in the next, bypassed on back-to-back hits.
// Reset: parser returns to idle, frame_mode is 1, all counters read as zero at
//   once through per-entry valid bits.
// Stall: while rsp_tready is low, the output register holds its transaction;
//   bytes that complete no frame keep flowing, a completing byte waits once the
//   counter stage is also full, and req_tready drops only then.
module uart_command_frame_parser #(
   parameter int TALLY_ENTRIES = uart_cfp_pkg::TALLY_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_data,    // [0] frame_mode
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [uart_cfp_pkg::REQ_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [uart_cfp_pkg::RSP_W-1:0] rsp_tdata    // [7:0] command, [15:8] payload,
                                                       // [23:16] command_tally, [24] counted
);

   localparam int IDX_W = (TALLY_ENTRIES > 1) ? $clog2(TALLY_ENTRIES) : 1;

   logic                     mode_ff;
   logic                     a_valid_ff;
   logic [7:0]               a_byte_ff;
   uart_cfp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]               func_ff, func_in;
   logic [7:0]               pcmd_ff, pcmd_in;
   logic [7:0]               ppay_ff, ppay_in;
   logic [7:0]               lpay_ff, lpay_in;
   logic                     a_done;
   uart_cfp_pkg::finish_type fin;

   logic                     b_valid_ff;
   uart_cfp_pkg::finish_type b_fin_ff;
   logic [7:0]               b_rd_ff;
   logic                     b_rdv_ff;
   logic [7:0]               new_tally;

   logic                     o_valid_ff;
   logic [uart_cfp_pkg::RSP_W-1:0] o_data_ff;

   logic [7:0]               tally_mem [TALLY_ENTRIES];
   logic [TALLY_ENTRIES-1:0] tally_vld_ff;

   logic a_fire, b_ready, b_fire, o_ready, req_fire;
   logic [IDX_W-1:0] a_idx, b_idx;

   assign o_ready    = !o_valid_ff || rsp_tready;
   assign b_ready    = !b_valid_ff || o_ready;
   assign b_fire     = b_valid_ff && o_ready;
   assign a_fire     = a_valid_ff && (!a_done || b_ready);
   assign req_tready = !a_valid_ff || a_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;

   assign a_idx     = pcmd_ff[IDX_W-1:0];
   assign b_idx     = b_fin_ff.command[IDX_W-1:0];
   assign new_tally = (b_rdv_ff ? b_rd_ff : 8'd0) + 8'd1;

   // parser next state
   always_comb begin
      phase_in = phase_ff;
      if (a_byte_ff == uart_cfp_pkg::BYTE_START) begin
         phase_in = uart_cfp_pkg::PH_FUNC;
      end else begin
         unique case (phase_ff)
            uart_cfp_pkg::PH_FUNC: begin
               if (mode_ff || a_byte_ff == uart_cfp_pkg::FUNC_CMD_ONLY) begin
                  phase_in = uart_cfp_pkg::PH_BODY;
               end
            end
            uart_cfp_pkg::PH_BODY: begin
               if (!mode_ff || func_ff == uart_cfp_pkg::FUNC_CMD_ONLY) begin
                  phase_in = uart_cfp_pkg::PH_CR;
               end else if (func_ff == uart_cfp_pkg::FUNC_CMD_DATA && pcmd_ff != 8'd0) begin
                  phase_in = uart_cfp_pkg::PH_CR;
               end
            end
            uart_cfp_pkg::PH_CR: begin
               if (a_byte_ff == uart_cfp_pkg::BYTE_CR) begin
                  phase_in = uart_cfp_pkg::PH_LF;
               end
            end
            uart_cfp_pkg::PH_LF: begin
               if (a_byte_ff == uart_cfp_pkg::BYTE_LF) begin
                  phase_in = uart_cfp_pkg::PH_IDLE;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // parser outputs and data updates
   always_comb begin
      func_in     = func_ff;
      pcmd_in     = pcmd_ff;
      ppay_in     = ppay_ff;
      lpay_in     = lpay_ff;
      a_done      = 1'b0;
      fin.command = pcmd_ff;
      fin.payload = mode_ff ? ppay_ff : lpay_ff;
      fin.counted = ({1'b0, pcmd_ff} < 9'(TALLY_ENTRIES));
      if (a_byte_ff != uart_cfp_pkg::BYTE_START) begin
         unique case (phase_ff)
            uart_cfp_pkg::PH_FUNC: begin
               if (mode_ff) begin
                  func_in = a_byte_ff;
               end
            end
            uart_cfp_pkg::PH_BODY: begin
               if (!mode_ff || func_ff == uart_cfp_pkg::FUNC_CMD_ONLY) begin
                  pcmd_in = a_byte_ff;
               end else if (func_ff == uart_cfp_pkg::FUNC_CMD_DATA) begin
                  if (pcmd_ff == 8'd0) begin
                     pcmd_in = a_byte_ff;
                  end else begin
                     ppay_in = a_byte_ff;
                  end
               end
            end
            uart_cfp_pkg::PH_LF: begin
               if (a_byte_ff == uart_cfp_pkg::BYTE_LF) begin
                  a_done = 1'b1;
                  if (mode_ff) begin
                     lpay_in = ppay_ff;
                     pcmd_in = 8'd0;
                     ppay_in = 8'd0;
                  end
               end
            end
            default: a_done = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         a_valid_ff   <= 1'b0;
         phase_ff     <= uart_cfp_pkg::PH_IDLE;
         func_ff      <= 8'd0;
         pcmd_ff      <= 8'd0;
         ppay_ff      <= 8'd0;
         lpay_ff      <= 8'd0;
         b_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
         tally_vld_ff <= '0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_data[0];
         end
         if (req_fire) begin
            a_valid_ff <= 1'b1;
         end else if (a_fire) begin
            a_valid_ff <= 1'b0;
         end
         if (a_fire) begin
            phase_ff <= phase_in;
            func_ff  <= func_in;
            pcmd_ff  <= pcmd_in;
            ppay_ff  <= ppay_in;
            lpay_ff  <= lpay_in;
         end
         if (b_ready) begin
            b_valid_ff <= a_fire && a_done;
         end
         if (o_ready) begin
            o_valid_ff <= b_valid_ff;
         end
         if (b_fire && b_fin_ff.counted) begin
            tally_vld_ff[b_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_byte_ff <= req_tdata;
      end
      if (a_fire && a_done) begin
         b_fin_ff <= fin;
         if (b_fire && b_fin_ff.counted && b_idx == a_idx) begin
            b_rd_ff  <= new_tally;
            b_rdv_ff <= 1'b1;
         end else if (fin.counted) begin
            b_rd_ff  <= tally_mem[a_idx];
            b_rdv_ff <= tally_vld_ff[a_idx];
         end else begin
            b_rd_ff  <= 8'd0;
            b_rdv_ff <= 1'b0;
         end
      end
      if (b_fire) begin
         if (b_fin_ff.counted) begin
            tally_mem[b_idx] <= new_tally;
         end
         o_data_ff <= {7'd0, b_fin_ff.counted,
                       b_fin_ff.counted ? new_tally : 8'd0,
                       b_fin_ff.payload, b_fin_ff.command};
      end
   end

endmodule

[hdl/uart_cfp_checker.sv]
// Port-level checker for the UART command frame parser, with its bind.
module uart_cfp_checker #(
   parameter int TALLY_ENTRIES = uart_cfp_pkg::TALLY_ENTRIES_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [uart_cfp_pkg::RSP_W-1:0] rsp_tdata
);

   // no result transaction right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input side is open right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // counted flag matches table range
   a_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[24] == ({1'b0, rsp_tdata[7:0]} < 9'(TALLY_ENTRIES)))
      else $error("counted flag wrong");

   // pad bits are zero and an uncounted command reports a zero tally
   a_tally: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] == 7'd0 && (rsp_tdata[24] || rsp_tdata[23:16] == 8'd0))
      else $error("tally field wrong");

endmodule

bind uart_command_frame_parser uart_cfp_checker #(.TALLY_ENTRIES(TALLY_ENTRIES)) u_cfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb_uart_command_frame_parser.sv]
// Testbench for the UART command frame parser: directed and random frames, checked by a predictor.
module tb_uart_command_frame_parser;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] payload;
      logic [7:0] tally;
      logic       counted;
   } frame_out_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [0:0]                       csr_data = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [uart_cfp_pkg::REQ_W-1:0]   req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [uart_cfp_pkg::RSP_W-1:0]   rsp_tdata;

   // predictor state
   logic                     frame_mode_q = 1'b1;
   uart_cfp_pkg::phase_type  phase_q = uart_cfp_pkg::PH_IDLE;
   logic [7:0]               func_q = 8'h00;
   logic [7:0]               pend_cmd_q = 8'h00;
   logic [7:0]               pend_pay_q = 8'h00;
   logic [7:0]               last_cmd_q = 8'h04;
   logic [7:0]               last_pay_q = 8'h00;
   logic [7:0]               cmd_tally [uart_cfp_pkg::TALLY_ENTRIES_DEF];

   frame_out_type       expected_frames [$];
   int                  fail_count = 0;
   int                  burst_left = 0;
   int                  frame_bytes = 0;
   int                  rx_cycle = 0;
   int                  rx_mode = 0;

   uart_command_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void predict_rx(input logic [7:0] b);
      frame_out_type f;
      if (b == uart_cfp_pkg::BYTE_START) begin
         phase_q = uart_cfp_pkg::PH_FUNC;
         return;
      end
      case (phase_q)
         uart_cfp_pkg::PH_FUNC: begin
            if (!frame_mode_q) begin
               if (b == uart_cfp_pkg::FUNC_CMD_ONLY) phase_q = uart_cfp_pkg::PH_BODY;
            end else begin
               func_q = b;
               phase_q = uart_cfp_pkg::PH_BODY;
            end
         end
         uart_cfp_pkg::PH_BODY: begin
            if (!frame_mode_q || func_q == uart_cfp_pkg::FUNC_CMD_ONLY) begin
               pend_cmd_q = b;
               phase_q = uart_cfp_pkg::PH_CR;
            end else if (func_q == uart_cfp_pkg::FUNC_CMD_DATA) begin
               if (pend_cmd_q == 8'h00) begin
                  pend_cmd_q = b;
               end else begin
                  pend_pay_q = b;
                  phase_q = uart_cfp_pkg::PH_CR;
               end
            end
         end
         uart_cfp_pkg::PH_CR: begin
            if (b == uart_cfp_pkg::BYTE_CR) phase_q = uart_cfp_pkg::PH_LF;
         end
         uart_cfp_pkg::PH_LF: begin
            if (b == uart_cfp_pkg::BYTE_LF) begin
               last_cmd_q = pend_cmd_q;
               if (frame_mode_q) begin
                  last_pay_q = pend_pay_q;
                  pend_cmd_q = 8'h00;
                  pend_pay_q = 8'h00;
               end
               f.command = last_cmd_q;
               f.payload = last_pay_q;
               f.tally = 8'h00;
               f.counted = 1'b0;
               if (last_cmd_q < uart_cfp_pkg::TALLY_ENTRIES_DEF) begin
                  cmd_tally[last_cmd_q] = cmd_tally[last_cmd_q] + 8'd1;
                  f.tally = cmd_tally[last_cmd_q];
                  f.counted = 1'b1;
               end
               phase_q = uart_cfp_pkg::PH_IDLE;
               expected_frames.push_back(f);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t mismatch %s: got %02h expected %02h", $realtime, what, got, want);
      fail_count++;
   endtask

   // sender bursts with random gaps; occasional long bursts with no gap
   task automatic send_rx(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predict_rx(b);
   endtask

   task automatic write_frame_mode(input logic mode);
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      frame_mode_q = mode;
   endtask

   task automatic send_random_frame(input logic mode);
      int r;
      int n;
      logic [7:0] fn;
      logic [7:0] cmd;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         n = $urandom_range(1, 4);
         repeat (n) send_rx(8'($urandom_range(0, 255)));
         return;
      end
      r = $urandom_range(0, 99);
      if (mode)
         fn = (r < 45) ? uart_cfp_pkg::FUNC_CMD_ONLY :
              (r < 90) ? uart_cfp_pkg::FUNC_CMD_DATA : 8'($urandom_range(0, 255));
      else
         fn = (r < 90) ? uart_cfp_pkg::FUNC_CMD_ONLY : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      cmd = (r < 6) ? 8'($urandom_range(0, 39)) : (r == 6) ? 8'h00 : 8'($urandom_range(0, 255));
      send_rx(uart_cfp_pkg::BYTE_START);
      send_rx(fn);
      send_rx(cmd);
      frame_bytes += 3;
      if (mode && fn == uart_cfp_pkg::FUNC_CMD_DATA) begin
         if (cmd == 8'h00) begin
            send_rx(8'($urandom_range(1, 255)));
            frame_bytes++;
         end
         send_rx(8'($urandom_range(0, 255)));
         frame_bytes++;
      end
      if ($urandom_range(0, 19) == 0) return;
      if ($urandom_range(0, 19) == 0) send_rx(8'($urandom_range(0, 255)));
      send_rx(uart_cfp_pkg::BYTE_CR);
      send_rx(uart_cfp_pkg::BYTE_LF);
      frame_bytes += 2;
   endtask

   task automatic test_mode1_frames();
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(uart_cfp_pkg::FUNC_CMD_ONLY); send_rx(8'h00);
      send_rx(uart_cfp_pkg::BYTE_CR); send_rx(uart_cfp_pkg::BYTE_LF);
      // zero command is taken again, then 0x28 is out of the table
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(uart_cfp_pkg::FUNC_CMD_DATA);
      send_rx(8'h00); send_rx(8'h28);
      send_rx(8'hFF); send_rx(uart_cfp_pkg::BYTE_CR); send_rx(uart_cfp_pkg::BYTE_LF);
   endtask

   task automatic test_ignored_bytes();
      // unknown function, then restart; stray bytes in the CR and LF phases
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(8'h55);
      send_rx(uart_cfp_pkg::BYTE_CR); send_rx(uart_cfp_pkg::BYTE_LF);
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(uart_cfp_pkg::FUNC_CMD_ONLY);
      send_rx(8'h27); send_rx(8'h77);
      send_rx(uart_cfp_pkg::BYTE_CR); send_rx(8'h99); send_rx(uart_cfp_pkg::BYTE_LF);
   endtask

   task automatic test_mode0_frames();
      write_frame_mode(1'b0);
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(uart_cfp_pkg::FUNC_CMD_DATA);
      send_rx(uart_cfp_pkg::FUNC_CMD_ONLY); send_rx(8'hFF);
      send_rx(uart_cfp_pkg::BYTE_CR); send_rx(uart_cfp_pkg::BYTE_LF);
      // mode switch in the middle of a frame
      send_rx(uart_cfp_pkg::BYTE_START); send_rx(uart_cfp_pkg::FUNC_CMD_ONLY);
      write_frame_mode(1'b1);
      send_rx(8'h03); send_rx(uart_cfp_pkg::BYTE_CR); send_rx(uart_cfp_pkg::BYTE_LF);
   endtask

   task automatic test_random_frames();
      int target;
      logic mode;
      for (int p = 0; p < 6; p++) begin
         mode = (p % 2 == 0);
         write_frame_mode(mode);
         target = frame_bytes + (mode ? 220 : 120);
         while (frame_bytes < target) send_random_frame(mode);
      end
   endtask

   // receiver stall pattern; a new mode is drawn each time its countdown runs out
   always @(posedge clock) begin
      if (rx_cycle == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_cycle <= $urandom_range(16, 80);
      end else begin
         rx_cycle <= rx_cycle - 1;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_cycle % 16 == 0);
      endcase
   end

   always @(posedge clock) begin : check_frames
      frame_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("unexpected frame, command", rsp_tdata[7:0], 8'h00);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tdata[7:0] !== want.command)
               report_mismatch("command", rsp_tdata[7:0], want.command);
            if (rsp_tdata[15:8] !== want.payload)
               report_mismatch("payload", rsp_tdata[15:8], want.payload);
            if (rsp_tdata[23:16] !== want.tally)
               report_mismatch("command_tally", rsp_tdata[23:16], want.tally);
            if (rsp_tdata[24] !== want.counted)
               report_mismatch("counted", {7'd0, rsp_tdata[24]}, {7'd0, want.counted});
         end
      end
   end

   initial begin
      for (int i = 0; i < uart_cfp_pkg::TALLY_ENTRIES_DEF; i++) cmd_tally[i] = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_mode1_frames();
      test_ignored_bytes();
      test_mode0_frames();
      test_random_frames();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
hdl/uart_cfp_pkg.sv
hdl/uart_command_frame_parser.sv
hdl/uart_cfp_checker.sv
tb/tb_uart_command_frame_parser.sv
